### rtl/bodq_pkg.sv
// Shared constants, threshold matrix and stage-control type for the
// ordered-dither quantizer. No dependencies.
package bodq_pkg;

  localparam int unsigned PixW   = 8;   // bits per color channel
  localparam int unsigned CoordW = 12;  // column / row width
  localparam int unsigned DepthW = 4;   // bits_per_channel register width
  localparam int unsigned ShW    = 4;   // step shift, 0..PixW
  localparam int unsigned ThrW   = 4;   // Bayer entry width
  localparam int unsigned CmpW   = PixW + ThrW;  // width of both sides of the test

  localparam logic [DepthW-1:0] DepthMax   = DepthW'(PixW);
  localparam logic [DepthW-1:0] DepthReset = DepthW'(1);

  // 4x4 Bayer matrix, indexed [column mod 4][row mod 4]
  localparam logic [ThrW-1:0] BayerTab [0:3][0:3] = '{
    '{4'd15, 4'd7,  4'd13, 4'd5},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd0,  4'd8,  4'd2,  4'd10}
  };

  // load enables for the per-channel stages
  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } stage_ctl_t;

endpackage

### rtl/bayer_ordered_dither_quantizer.sv
// Top level of the 4x4 Bayer ordered-dither quantizer: config register,
// stage 1 and the valid/ready chain. Depends on bodq_pkg and bodq_chan.
//
//  channel  | signals                                         | dir
//  ---------+-------------------------------------------------+-----
//  input    | in_valid, in_ready, red_in, green_in, blue_in,  | in
//           | column, row                                     |
//  output   | out_valid, out_ready, red_out, green_out,       | out
//           | blue_out                                        |
//  config   | cfg_valid, cfg_ready, cfg_data                  | in
//
// One word per clock unless an out_ready stall holds the chain; three register
// stages (threshold/mask, remainder and candidates, compare/select), stage 3
// driving the outputs. Each stage has its own valid bit and loads when
// empty or when its successor loads: bubbles squeeze out and an out_ready
// stall holds every word in place. rst (synchronous) clears the valid bits
// and sets bits_per_channel to 1; cfg_ready is always high.
module bayer_ordered_dither_quantizer (
  input  logic                            clk,
  input  logic                            rst,
  // input word
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bodq_pkg::PixW-1:0]       red_in,
  input  logic [bodq_pkg::PixW-1:0]       green_in,
  input  logic [bodq_pkg::PixW-1:0]       blue_in,
  input  logic [bodq_pkg::CoordW-1:0]     column,
  input  logic [bodq_pkg::CoordW-1:0]     row,
  // output word
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bodq_pkg::PixW-1:0]       red_out,
  output logic [bodq_pkg::PixW-1:0]       green_out,
  output logic [bodq_pkg::PixW-1:0]       blue_out,
  // config write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bodq_pkg::DepthW-1:0]     cfg_data
);

  logic [bodq_pkg::DepthW-1:0] bits_per_channel;

  // pipeline valid bits and stage loads
  logic s1_valid, s2_valid, s3_valid;
  logic s1_load, s2_load, s3_load;
  bodq_pkg::stage_ctl_t ctl;

  // stage 1 registers
  logic [bodq_pkg::PixW-1:0] s1_red, s1_green, s1_blue;
  logic [bodq_pkg::PixW-1:0] s1_mask;
  logic [bodq_pkg::CmpW-1:0] s1_thr_scaled;

  // stage 1 logic
  logic [bodq_pkg::DepthW-1:0] depth_sat;
  logic [bodq_pkg::ShW-1:0]    step_sh;    // log2(delta)
  logic [bodq_pkg::ThrW-1:0]   thr;
  logic [bodq_pkg::PixW-1:0]   mask_next;
  logic [bodq_pkg::CmpW-1:0]   thr_scaled_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_channel <= bodq_pkg::DepthReset;
    end else if (cfg_valid && cfg_ready) begin
      bits_per_channel <= cfg_data;
    end
  end

  // handshake chain: a stage loads when upstream has a word and it is
  // empty or draining this cycle
  assign s3_load  = s2_valid && (!s3_valid || out_ready);
  assign s2_load  = s1_valid && (!s2_valid || s3_load);
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;
  assign out_valid = s3_valid;

  assign ctl.s2_en = s2_load;
  assign ctl.s3_en = s3_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (!s2_valid || s3_load) begin
        s2_valid <= s1_valid;
      end
      if (!s3_valid || out_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // depths above 8 saturate to 8 (delta = 1)
  always_comb begin
    depth_sat = (bits_per_channel > bodq_pkg::DepthMax) ? bodq_pkg::DepthMax
                                                        : bits_per_channel;
    step_sh         = bodq_pkg::ShW'(bodq_pkg::PixW) - bodq_pkg::ShW'(depth_sat);
    thr             = bodq_pkg::BayerTab[column[1:0]][row[1:0]];
    mask_next       = {bodq_pkg::PixW{1'b1}} >> depth_sat;   // delta - 1
    thr_scaled_next = bodq_pkg::CmpW'(thr) << step_sh;      // thr * delta
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_red        <= red_in;
      s1_green      <= green_in;
      s1_blue       <= blue_in;
      s1_mask       <= mask_next;
      s1_thr_scaled <= thr_scaled_next;
    end
  end

  bodq_chan u_red (
    .clk        (clk),
    .ctl        (ctl),
    .pix        (s1_red),
    .mask       (s1_mask),
    .thr_scaled (s1_thr_scaled),
    .pix_out    (red_out)
  );

  bodq_chan u_green (
    .clk        (clk),
    .ctl        (ctl),
    .pix        (s1_green),
    .mask       (s1_mask),
    .thr_scaled (s1_thr_scaled),
    .pix_out    (green_out)
  );

  bodq_chan u_blue (
    .clk        (clk),
    .ctl        (ctl),
    .pix        (s1_blue),
    .mask       (s1_mask),
    .thr_scaled (s1_thr_scaled),
    .pix_out    (blue_out)
  );

endmodule

### rtl/bodq_chan.sv
// One color channel, stages 2 and 3 of the quantizer pipeline.
// Depends on bodq_pkg.
module bodq_chan (
  input  logic                          clk,
  input  bodq_pkg::stage_ctl_t          ctl,
  input  logic [bodq_pkg::PixW-1:0]     pix,
  input  logic [bodq_pkg::PixW-1:0]     mask,
  input  logic [bodq_pkg::CmpW-1:0]     thr_scaled,
  output logic [bodq_pkg::PixW-1:0]     pix_out
);

  // stage 2: remainder scaled by 16, both candidate outputs
  logic [bodq_pkg::CmpW-1:0] rem16;
  logic [bodq_pkg::CmpW-1:0] thr_s2;
  logic [bodq_pkg::PixW-1:0] up_val;
  logic [bodq_pkg::PixW-1:0] base_val;
  logic [bodq_pkg::PixW-1:0] pix_next;

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      rem16    <= {pix & mask, 4'b0000};
      thr_s2   <= thr_scaled;
      up_val   <= pix | mask;     // (q+1)*delta - 1
      base_val <= pix & ~mask;    // q*delta
    end
  end

  // stage 3: compare and select, clamp base-1 at zero
  always_comb begin
    if (rem16 > thr_s2) begin
      pix_next = up_val;
    end else if (base_val == '0) begin
      pix_next = '0;
    end else begin
      pix_next = base_val - bodq_pkg::PixW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      pix_out <= pix_next;
    end
  end

endmodule

### rtl/bodq_check.sv
// Port-level checker for the quantizer, bound to the top level.
// Depends on bodq_pkg and bayer_ordered_dither_quantizer.
module bodq_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bodq_pkg::PixW-1:0]   red_out,
  input logic [bodq_pkg::PixW-1:0]   green_out,
  input logic [bodq_pkg::PixW-1:0]   blue_out,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) &&
      $stable(green_out) && $stable(blue_out))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // an output that is empty or draining never blocks the input
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with a free output");

  // config writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind bayer_ordered_dither_quantizer bodq_check u_bodq_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
